[sv/tmcs_pkg.sv]
// Package for the tile map collision side block.
// Holds sizes, codes, handshake structs and the row/column limit helper.
// No dependencies.
`default_nettype none

package tmcs_pkg;

  localparam int MaxRows  = 64;
  localparam int MaxCols  = 64;
  localparam int IdxW     = 6;               // row or column index
  localparam int AddrW    = 2 * IdxW;        // flat map address {row, col}
  localparam int Depth    = MaxRows * MaxCols;
  localparam int CntW     = 7;               // row_count / col_count registers
  localparam int CoordW   = 16;              // rect_x, rect_y
  localparam int SizeW    = 13;              // rect_w, rect_h
  localparam int DvdW     = 16;              // divider dividend magnitude
  localparam int DvsW     = 13;              // divider divisor
  localparam int DivCntW  = 4;               // iteration counter, 0 .. DvdW-1
  localparam int TileW    = 17;              // signed tile coordinate
  localparam int CentreW  = 18;              // doubled centre
  localparam int VoteW    = 14;              // signed vote, up to +/- 4096
  localparam int SideW    = 3;

  // Input tdata layout, lowest bit first.
  localparam int InRowLo  = 0;
  localparam int InColLo  = InRowLo + IdxW;
  localparam int InSolid  = InColLo + IdxW;
  localparam int InXLo    = InSolid + 1;
  localparam int InYLo    = InXLo + CoordW;
  localparam int InWLo    = InYLo + CoordW;
  localparam int InHLo    = InWLo + SizeW;
  localparam int InBits   = InHLo + SizeW;
  localparam int InDataW  = ((InBits + 7) / 8) * 8;
  localparam int OutDataW = 8;

  localparam logic FuncWrite = 1'b0;
  localparam logic FuncQuery = 1'b1;

  localparam logic CfgRowCount = 1'b0;
  localparam logic CfgColCount = 1'b1;

  typedef enum logic [SideW-1:0] {
    SideNone  = 3'd0,
    SideLeft  = 3'd1,
    SideRight = 3'd2,
    SideUp    = 3'd3,
    SideDown  = 3'd4
  } side_e;

  typedef struct packed {
    logic             en;
    logic [AddrW-1:0] addr;
    logic             data;
  } map_wr_t;

  typedef struct packed {
    logic            start;
    logic [DvdW-1:0] dividend;
    logic [DvsW-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic            done;
    logic            busy;
    logic [DvdW-1:0] quot;
    logic [DvsW-1:0] rem;
  } div_rsp_t;

  // Last usable index for a count register: zero acts as one, and a count
  // above the store size acts as the store size.
  function automatic logic [IdxW-1:0] last_index(input logic [CntW-1:0] cnt,
                                                 input int unsigned max_n);
    logic [IdxW-1:0] res;
    if (cnt == '0) begin
      res = '0;
    end else if (cnt > CntW'(max_n)) begin
      res = IdxW'(max_n - 1);
    end else begin
      res = IdxW'(cnt - 1'b1);
    end
    return res;
  endfunction

endpackage

`default_nettype wire

[sv/tmcs_div.sv]
// Shared restoring divider: unsigned 16-bit dividend by 13-bit divisor,
// one quotient bit per cycle. Depends on tmcs_pkg.
`default_nettype none

module tmcs_div import tmcs_pkg::*; (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire div_req_t req_i,
  output div_rsp_t      rsp_o
);

  logic               busy_q, busy_d;
  logic               done_q, done_d;
  logic [DivCntW-1:0] cnt_q, cnt_d;
  logic [DvdW-1:0]    dvd_q, dvd_d;
  logic [DvsW-1:0]    dvs_q, dvs_d;
  logic [DvsW-1:0]    rem_q, rem_d;
  logic [DvsW:0]      rem_sh;
  logic [DvsW:0]      rem_sub;
  logic               ge;

  // The dividend register shifts out its top bit and takes the quotient bit.
  assign rem_sh  = {rem_q, dvd_q[DvdW-1]};
  assign ge      = rem_sh >= {1'b0, dvs_q};
  assign rem_sub = rem_sh - {1'b0, dvs_q};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    dvd_d  = dvd_q;
    dvs_d  = dvs_q;
    rem_d  = rem_q;
    if (req_i.start) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      dvd_d  = req_i.dividend;
      dvs_d  = req_i.divisor;
      rem_d  = '0;
    end else if (busy_q) begin
      dvd_d = {dvd_q[DvdW-2:0], ge};
      rem_d = ge ? rem_sub[DvsW-1:0] : rem_sh[DvsW-1:0];
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == DivCntW'(DvdW - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dvd_q <= dvd_d;
    dvs_q <= dvs_d;
    rem_q <= rem_d;
  end

  assign rsp_o.done = done_q;
  assign rsp_o.busy = busy_q;
  assign rsp_o.quot = dvd_q;
  assign rsp_o.rem  = rem_q;

endmodule

`default_nettype wire

[sv/tmcs_map.sv]
// Solid tile flag store, one bit per tile, with a clearing sweep after reset.
// Read data is registered. Depends on tmcs_pkg.
`default_nettype none

module tmcs_map import tmcs_pkg::*; (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire map_wr_t          wr_i,
  input  wire logic [AddrW-1:0] rd_addr_i,
  output logic                  rd_data_o,
  output logic                  ready_o
);

  logic             mem [Depth];
  logic             clr_q;
  logic [AddrW-1:0] clr_cnt_q;
  logic             rd_data_q;
  logic             we;
  logic [AddrW-1:0] waddr;
  logic             wdata;

  // The sweep owns the write port until every entry has been cleared.
  assign we    = clr_q | wr_i.en;
  assign waddr = clr_q ? clr_cnt_q : wr_i.addr;
  assign wdata = clr_q ? 1'b0 : wr_i.data;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q     <= 1'b1;
      clr_cnt_q <= '0;
    end else if (clr_q) begin
      clr_cnt_q <= clr_cnt_q + 1'b1;
      if (clr_cnt_q == AddrW'(Depth - 1)) begin
        clr_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rd_data_q <= mem[rd_addr_i];
  end

  assign rd_data_o = rd_data_q;
  assign ready_o   = ~clr_q;

endmodule

`default_nettype wire

[sv/tile_map_collision_side.sv]
// Top level of the tile map collision side block: stream ports, sequencer,
// votes and result register. Depends on tmcs_pkg, tmcs_div and tmcs_map.
//
//   Port group  Dir  Contents
//   s_axis      in   tuser: func; tdata: tile_row, tile_col, tile_solid,
//                    rect_x, rect_y, rect_w, rect_h
//   m_axis      out  tdata: side
//   cfg         in   index 0 row_count, index 1 col_count
//
// A tile write is done at its transfer, and a query with zero width goes
// straight to emit with side none. Any other query runs three passes of
// the shared divider, a step to clamp the span, a walk over the covered
// tiles (one map read a cycle), then drain, decide and emit; walk and
// drain are skipped when the clamped span is empty.
// After reset all 4096 map entries are cleared, during which no item is
// taken; configuration writes are always taken.
// A finished result waits in the output register; the next item may be
// taken meanwhile, and a query only stalls at its end if that register is
// still full.
`default_nettype none

module tile_map_collision_side import tmcs_pkg::*; (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                s_axis_tvalid,
  output logic                     s_axis_tready,
  // tdata, lowest bit up: tile_row, tile_col, tile_solid, rect_x, rect_y,
  // rect_w, rect_h, one zero pad bit
  input  wire logic [InDataW-1:0]  s_axis_tdata,
  // tuser: func
  input  wire logic                s_axis_tuser,
  output logic                     m_axis_tvalid,
  input  wire logic                m_axis_tready,
  // tdata, lowest bit up: side, five zero pad bits
  output logic [OutDataW-1:0]      m_axis_tdata,
  input  wire logic                cfg_valid_i,
  output logic                     cfg_ready_o,
  input  wire logic                cfg_index_i,
  input  wire logic [CntW-1:0]     cfg_data_i
);

  typedef enum logic [8:0] {
    StIdle   = 9'b000000001,
    StDivX   = 9'b000000010,
    StDivY   = 9'b000000100,
    StDivB   = 9'b000001000,
    StPrep   = 9'b000010000,
    StWalk   = 9'b000100000,
    StDrain  = 9'b001000000,
    StDecide = 9'b010000000,
    StEmit   = 9'b100000000
  } state_e;

  state_e state_q, state_d;

  logic [CntW-1:0] row_cnt_q, col_cnt_q;

  // Input fields.
  logic [IdxW-1:0]          in_row, in_col;
  logic                     in_solid;
  logic signed [CoordW-1:0] in_x, in_y;
  logic [SizeW-1:0]         in_w, in_h;
  logic                     in_acc;

  assign in_row   = s_axis_tdata[InColLo-1:InRowLo];
  assign in_col   = s_axis_tdata[InSolid-1:InColLo];
  assign in_solid = s_axis_tdata[InSolid];
  assign in_x     = s_axis_tdata[InYLo-1:InXLo];
  assign in_y     = s_axis_tdata[InWLo-1:InYLo];
  assign in_w     = s_axis_tdata[InHLo-1:InWLo];
  assign in_h     = s_axis_tdata[InBits-1:InHLo];
  assign in_acc   = s_axis_tvalid & s_axis_tready;

  // Query operands and spans.
  logic signed [CoordW-1:0]  x_q, x_d, y_q, y_d;
  logic [SizeW-1:0]          w_q, w_d, h_q, h_d;
  logic signed [TileW-1:0]   left_q, left_d, right_q, right_d;
  logic signed [TileW-1:0]   top_q, top_d, bot_q, bot_d;
  logic signed [CentreW-1:0] cx2_q, cx2_d, cy2_q, cy2_d;
  logic [IdxW-1:0]           i_q, i_d, j_q, j_d, i_end_q, i_end_d;
  logic [IdxW-1:0]           j_beg_q, j_beg_d, j_end_q, j_end_d;

  // Read pipeline and votes.
  logic                    pv_q, pv_d, plx_q, plx_d, ply_q, ply_d;
  logic signed [VoteW-1:0] xv_q, xv_d, yv_q, yv_d;
  logic                    clr_votes;

  side_e res_q, res_d;
  logic  out_vld_q, out_vld_d;
  side_e out_side_q, out_side_d;

  div_req_t div_req;
  div_rsp_t div_rsp;
  map_wr_t  map_wr;
  logic     map_rd_data;
  logic     map_ready;

  // Working values.
  logic signed [TileW-1:0] yh;
  logic [DvdW-1:0]         yh_mag;
  logic signed [TileW-1:0] quot_s;
  logic                    quot_neg;
  logic signed [TileW-1:0] leftc, rightc, topc, botc;
  logic signed [TileW-1:0] col_lim, row_lim;
  logic [VoteW-1:0]        xv_abs, yv_abs;

  assign yh     = TileW'(y_q) + $signed({{(TileW - SizeW){1'b0}}, h_q});
  assign yh_mag = yh[TileW-1] ? DvdW'(-yh) : DvdW'(yh);

  always_comb begin
    quot_neg = 1'b0;
    if (state_q == StDivX || state_q == StDivY) begin
      quot_neg = y_q[CoordW-1];
      if (state_q == StDivX) begin
        quot_neg = x_q[CoordW-1];
      end
    end else begin
      quot_neg = yh[TileW-1];
    end
  end

  assign quot_s = quot_neg ? -$signed({1'b0, div_rsp.quot})
                           :  $signed({1'b0, div_rsp.quot});

  assign col_lim = $signed({{(TileW - IdxW){1'b0}}, last_index(col_cnt_q, MaxCols)});
  assign row_lim = $signed({{(TileW - IdxW){1'b0}}, last_index(row_cnt_q, MaxRows)});
  assign leftc   = left_q[TileW-1] ? '0 : left_q;
  assign topc    = top_q[TileW-1] ? '0 : top_q;
  assign rightc  = (right_q > col_lim) ? col_lim : right_q;
  assign botc    = (bot_q > row_lim) ? row_lim : bot_q;

  assign xv_abs = xv_q[VoteW-1] ? VoteW'(-xv_q) : VoteW'(xv_q);
  assign yv_abs = yv_q[VoteW-1] ? VoteW'(-yv_q) : VoteW'(yv_q);

  assign s_axis_tready = (state_q == StIdle) & map_ready;

  always_comb begin
    state_d    = state_q;
    x_d        = x_q;
    y_d        = y_q;
    w_d        = w_q;
    h_d        = h_q;
    left_d     = left_q;
    right_d    = right_q;
    top_d      = top_q;
    bot_d      = bot_q;
    cx2_d      = cx2_q;
    cy2_d      = cy2_q;
    i_d        = i_q;
    j_d        = j_q;
    i_end_d    = i_end_q;
    j_beg_d    = j_beg_q;
    j_end_d    = j_end_q;
    res_d      = res_q;
    clr_votes  = 1'b0;
    div_req    = '0;
    map_wr.en   = 1'b0;
    map_wr.addr = {in_row, in_col};
    map_wr.data = in_solid;
    pv_d       = 1'b0;
    plx_d      = plx_q;
    ply_d      = ply_q;
    out_vld_d  = out_vld_q & ~m_axis_tready;
    out_side_d = out_side_q;

    case (state_q)
      StIdle: begin
        if (in_acc) begin
          if (s_axis_tuser == FuncWrite) begin
            map_wr.en = 1'b1;
          end else begin
            x_d       = in_x;
            y_d       = in_y;
            w_d       = in_w;
            h_d       = in_h;
            clr_votes = 1'b1;
            if (in_w == '0) begin
              res_d   = SideNone;
              state_d = StEmit;
            end else begin
              div_req.start    = 1'b1;
              div_req.dividend = in_x[CoordW-1] ? DvdW'(-in_x) : DvdW'(in_x);
              div_req.divisor  = in_w;
              state_d          = StDivX;
            end
          end
        end
      end
      StDivX: begin
        if (div_rsp.done) begin
          left_d = quot_s;
          // (x + w) / w is one more than x / w, except for -w < x < 0.
          if (x_q[CoordW-1] && div_rsp.quot == '0 && div_rsp.rem != '0) begin
            right_d = '0;
          end else begin
            right_d = quot_s + TileW'(1);
          end
          div_req.start    = 1'b1;
          div_req.dividend = y_q[CoordW-1] ? DvdW'(-y_q) : DvdW'(y_q);
          div_req.divisor  = w_q;
          state_d          = StDivY;
        end
      end
      StDivY: begin
        if (div_rsp.done) begin
          top_d            = quot_s;
          div_req.start    = 1'b1;
          div_req.dividend = yh_mag;
          div_req.divisor  = w_q;
          state_d          = StDivB;
        end
      end
      StDivB: begin
        if (div_rsp.done) begin
          bot_d   = quot_s;
          state_d = StPrep;
        end
      end
      StPrep: begin
        cx2_d = CentreW'(left_q) + CentreW'(right_q);
        cy2_d = CentreW'(top_q) + CentreW'(bot_q);
        if (leftc > rightc || topc > botc) begin
          state_d = StDecide;
        end else begin
          i_d     = leftc[IdxW-1:0];
          j_d     = topc[IdxW-1:0];
          i_end_d = rightc[IdxW-1:0];
          j_beg_d = topc[IdxW-1:0];
          j_end_d = botc[IdxW-1:0];
          state_d = StWalk;
        end
      end
      StWalk: begin
        pv_d  = 1'b1;
        plx_d = $signed({{(CentreW - IdxW - 1){1'b0}}, i_q, 1'b0}) < cx2_q;
        ply_d = $signed({{(CentreW - IdxW - 1){1'b0}}, j_q, 1'b0}) < cy2_q;
        if (j_q == j_end_q) begin
          j_d = j_beg_q;
          if (i_q == i_end_q) begin
            state_d = StDrain;
          end else begin
            i_d = i_q + 1'b1;
          end
        end else begin
          j_d = j_q + 1'b1;
        end
      end
      StDrain: begin
        state_d = StDecide;
      end
      StDecide: begin
        if (xv_q == '0 && yv_q == '0) begin
          res_d = SideNone;
        end else if (xv_abs > yv_abs) begin
          res_d = xv_q[VoteW-1] ? SideLeft : SideRight;
        end else begin
          res_d = (!yv_q[VoteW-1] && yv_q != '0) ? SideDown : SideUp;
        end
        state_d = StEmit;
      end
      StEmit: begin
        if (!out_vld_q || m_axis_tready) begin
          out_vld_d  = 1'b1;
          out_side_d = res_q;
          state_d    = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_comb begin
    xv_d = xv_q;
    yv_d = yv_q;
    if (clr_votes) begin
      xv_d = '0;
      yv_d = '0;
    end else if (pv_q && map_rd_data) begin
      xv_d = plx_q ? xv_q - VoteW'(1) : xv_q + VoteW'(1);
      yv_d = ply_q ? yv_q - VoteW'(1) : yv_q + VoteW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= StIdle;
      row_cnt_q  <= CntW'(MaxRows);
      col_cnt_q  <= CntW'(MaxCols);
      out_vld_q  <= 1'b0;
      pv_q       <= 1'b0;
    end else begin
      state_q   <= state_d;
      out_vld_q <= out_vld_d;
      pv_q      <= pv_d;
      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_index_i)
          CfgRowCount: row_cnt_q <= cfg_data_i;
          CfgColCount: col_cnt_q <= cfg_data_i;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    x_q        <= x_d;
    y_q        <= y_d;
    w_q        <= w_d;
    h_q        <= h_d;
    left_q     <= left_d;
    right_q    <= right_d;
    top_q      <= top_d;
    bot_q      <= bot_d;
    cx2_q      <= cx2_d;
    cy2_q      <= cy2_d;
    i_q        <= i_d;
    j_q        <= j_d;
    i_end_q    <= i_end_d;
    j_beg_q    <= j_beg_d;
    j_end_q    <= j_end_d;
    plx_q      <= plx_d;
    ply_q      <= ply_d;
    xv_q       <= xv_d;
    yv_q       <= yv_d;
    res_q      <= res_d;
    out_side_q <= out_side_d;
  end

  tmcs_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  tmcs_map u_map (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_i      (map_wr),
    .rd_addr_i ({j_q, i_q}),
    .rd_data_o (map_rd_data),
    .ready_o   (map_ready)
  );

  assign cfg_ready_o   = 1'b1;
  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {{(OutDataW - SideW){1'b0}}, out_side_q};

`ifndef ASSERT_OFF
  a_no_item_while_clearing: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !map_ready |-> !s_axis_tready)
    else $error("item taken while the map is still being cleared");

  a_side_code_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (out_side_q <= SideDown))
    else $error("result side code out of range");

  a_walk_in_span: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StWalk) |-> ((i_q <= i_end_q) && (j_q <= j_end_q) && (j_beg_q <= j_q)))
    else $error("tile walk left its clamped span");

  a_result_from_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_vld_q) |-> $past(state_q == StEmit))
    else $error("result raised outside the emit step");

  a_div_start_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_req.start |-> !div_rsp.busy)
    else $error("divider started while busy");
`endif

endmodule

`default_nettype wire
